// ===== design/swhc_pkg.sv =====
// Shared types and constants for the sliding-window hit counter.
`default_nettype none

package swhc_pkg;

  localparam int BUCKETS_DEF = 512;
  localparam int TS_W        = 31;
  localparam int HITS_W      = 32;
  localparam int WIN_W       = 10;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;

  // Register index bit of the configuration address
  localparam logic REG_WINDOW = 1'b0;

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [TS_W-1:0]   tstamp;
    logic [HITS_W-1:0] hits;
  } bucket_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== design/swhc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module swhc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/swhc_front.sv =====
// Front end: accepts transactions and computes each timestamp's ring slot.
`default_nettype none

module swhc_front
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_cmd,
  input  wire logic [TS_W-1:0]            in_timestamp,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output logic                            push_cmd,
  output logic      [TS_W-1:0]            push_ts,
  output logic      [$clog2(BUCKETS)-1:0] push_slot
);

  localparam int AW     = $clog2(BUCKETS);
  localparam int RW     = AW + 1;
  localparam int K      = TS_W + AW;
  localparam int PW     = TS_W + 32;
  localparam logic [63:0] RECIP64 = (64'd1 << K) / BUCKETS;
  localparam logic [31:0] RECIP   = RECIP64[31:0];

  logic            s1_v_r;
  logic            s1_cmd_r;
  logic [TS_W-1:0] s1_ts_r;
  logic [PW-1:0]   s1_prod_r;
  logic            s2_v_r;
  logic            s2_cmd_r;
  logic [TS_W-1:0] s2_ts_r;
  logic [RW-1:0]   s2_rem_r;

  logic            s2_adv;
  logic            s1_open;
  logic [PW-1:0]   in_prod;
  logic [TS_W-1:0] s1_quot;
  logic [RW-1:0]   s1_qb;

  // Quotient estimate is low by at most one, so the remainder stays below 2*BUCKETS
  assign in_prod = PW'(in_timestamp) * PW'(RECIP);
  assign s1_quot = TS_W'(s1_prod_r >> K);
  assign s1_qb   = RW'(s1_quot) * RW'(BUCKETS);

  assign s2_adv   = !s2_v_r || push_ready;
  assign s1_open  = !s1_v_r || s2_adv;
  assign in_ready = s1_open && !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_v_r <= in_valid && in_ready;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_open) begin
      s1_cmd_r  <= in_cmd;
      s1_ts_r   <= in_timestamp;
      s1_prod_r <= in_prod;
    end
    if (s2_adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_ts_r  <= s1_ts_r;
      s2_rem_r <= RW'(s1_ts_r) - s1_qb;
    end
  end

  assign push_valid = s2_v_r;
  assign push_cmd   = s2_cmd_r;
  assign push_ts    = s2_ts_r;
  assign push_slot  = (s2_rem_r >= RW'(BUCKETS)) ? AW'(s2_rem_r - RW'(BUCKETS))
                                                 : AW'(s2_rem_r);

endmodule

`default_nettype wire

// ===== design/swhc_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none

module swhc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data,
  output logic      [1:0]       level
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = ent_r[rd_ptr_r];
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/swhc_back.sv =====
// Back end: bucket ring, hit update, query sweep and result register.
`default_nettype none

module swhc_back
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [WIN_W-1:0]           window,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire logic                       pop_cmd,
  input  wire logic [TS_W-1:0]            pop_ts,
  input  wire logic [$clog2(BUCKETS)-1:0] pop_slot,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [HITS_W-1:0]          out_hit_total,
  output back_stat_t                      stat
);

  localparam int AW = $clog2(BUCKETS);
  localparam logic [AW-1:0] LAST = AW'(BUCKETS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HIT   = 3'd2;
  localparam logic [2:0] ST_QRUN  = 3'd3;
  localparam logic [2:0] ST_QOUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [HITS_W-1:0] sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HITS_W-1:0] out_total_r, out_total_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  bucket_t           wdata;
  logic [$bits(bucket_t)-1:0] rdata;
  bucket_t           rd_b;
  logic [TS_W-1:0]   age;
  logic              in_win;
  logic [HITS_W:0]   sum_add;
  logic [HITS_W-1:0] sum_sat;

  swhc_ram #(
    .WIDTH ($bits(bucket_t)),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_b    = bucket_t'(rdata);
  assign age     = ts_r - rd_b.tstamp;
  assign in_win  = age < TS_W'(window);
  assign sum_add = {1'b0, sum_r} + {1'b0, rd_b.hits};
  assign sum_sat = sum_add[HITS_W] ? '1 : sum_add[HITS_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ts_nxt        = ts_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    pop_ready     = 1'b0;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = rd_b;
    raddr         = cnt_r + AW'(1);

    // Drop the result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wdata   = '0;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        raddr     = (pop_cmd == CMD_QUERY) ? '0 : pop_slot;
        if (pop_valid) begin
          ts_nxt    = pop_ts;
          slot_nxt  = pop_slot;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = (pop_cmd == CMD_QUERY) ? ST_QRUN : ST_HIT;
        end
      end
      ST_HIT: begin
        we    = 1'b1;
        waddr = slot_r;
        if (rd_b.vld && rd_b.tstamp == ts_r) begin
          wdata.hits = rd_b.hits + HITS_W'(rd_b.hits != '1);
        end else begin
          wdata.vld    = 1'b1;
          wdata.tstamp = ts_r;
          wdata.hits   = HITS_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_QRUN: begin
        // Data for bucket cnt_r arrives while the next bucket is being read
        if (rd_b.vld && rd_b.tstamp <= ts_r) begin
          if (in_win) begin
            sum_nxt = sum_sat;
          end else begin
            we        = 1'b1;
            wdata.vld = 1'b0;
          end
        end
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST) begin
          state_nxt = ST_QOUT;
        end
      end
      ST_QOUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r        <= ts_nxt;
    slot_r      <= slot_nxt;
    sum_r       <= sum_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit_total = out_total_r;
  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.idle     = (state_r == ST_IDLE);

endmodule

`default_nettype wire

// ===== design/sliding_window_hit_counter_core.sv =====
// Top level of the sliding-window hit counter.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | in_cmd, in_timestamp
//   out     | output    | out_valid / out_ready   | out_hit_total
//   cfg     | input     | psel, penable, pwrite   | paddr, pwdata, prdata
//
// A hit occupies the back end for a bucket read, then a write back.
// During a query the sweep reads one bucket a cycle through the single read port
// of the bucket RAM and writes expired ones back. The front end computes the
// slot in its registered stages s1 and s2; the queue holds two transactions so
// the front keeps accepting while a query sweeps until the queue and the front
// stages fill. After reset a clearing pass zeroes the RAM; in_ready is low until
// it ends. The result register lets the back end finish while out stalls.
`default_nettype none

module sliding_window_hit_counter_core
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  input  wire logic [TS_W-1:0]   in_timestamp,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [HITS_W-1:0] out_hit_total,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW = $clog2(BUCKETS);
  localparam int QW = 1 + TS_W + AW;

  logic [WIN_W-1:0] window_r;
  logic             cfg_wr;

  logic             push_valid;
  logic             push_ready;
  logic             push_cmd;
  logic [TS_W-1:0]  push_ts;
  logic [AW-1:0]    push_slot;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_data;
  logic [1:0]       q_level;
  back_stat_t       stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr && paddr[2] == REG_WINDOW) begin
      window_r <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? CFG_DW'(window_r) : '0;

  swhc_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (stat.clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_timestamp (in_timestamp),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd),
    .push_ts      (push_ts),
    .push_slot    (push_slot)
  );

  swhc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_ts, push_slot}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .level      (q_level)
  );

  swhc_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window        (window_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_data[QW-1]),
    .pop_ts        (pop_data[QW-2:AW]),
    .pop_slot      (pop_data[AW-1:0]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit_total (out_hit_total),
    .stat          (stat)
  );

  // No transaction enters while the RAM is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !(in_valid && in_ready))
    else $error("input accepted during clearing pass");

  // A waiting queue entry is taken up by an idle back end at once
  a_idle_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.idle && pop_valid) |=> !stat.idle)
    else $error("back end idle with a queued transaction");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= 2'd2)
    else $error("queue level out of range");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_valid)
    else $error("result shown during clearing pass");

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_hit_counter_checker.sv =====
// Scoreboard for the sliding-window hit counter: mirrors the bucket ring and scores each total.
`default_nettype none

module sliding_window_hit_counter_checker
  import swhc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              in_cmd,
  input  wire logic [TS_W-1:0]   in_timestamp,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [HITS_W-1:0] out_hit_total,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     open_totals
);

  logic [TS_W-1:0]   ring_time [BUCKETS];
  logic [HITS_W-1:0] ring_hits [BUCKETS];
  bit                ring_live [BUCKETS];
  logic [WIN_W-1:0]  window_len;
  logic [HITS_W-1:0] expected_totals [$];

  task automatic report_mismatch(input string what, input logic [HITS_W-1:0] want,
                                 input logic [HITS_W-1:0] got);
    $display("mismatch at %0t, %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  task automatic add_hit(input logic [TS_W-1:0] ts);
    int slot;
    slot = int'(ts % BUCKETS);
    if (ring_live[slot] && ring_time[slot] == ts) begin
      if (ring_hits[slot] != '1) ring_hits[slot]++;
    end else begin
      // slot held another timestamp or nothing: restart it
      ring_time[slot] = ts;
      ring_hits[slot] = 1;
      ring_live[slot] = 1'b1;
    end
  endtask

  // Sum live buckets inside the window and expire the ones that fell out of it.
  task automatic sweep_window(input logic [TS_W-1:0] now, output logic [HITS_W-1:0] total);
    logic [63:0]     acc;
    logic [TS_W-1:0] age;
    int              i;
    acc = '0;
    for (i = 0; i < BUCKETS; i++) begin
      if (ring_live[i] && ring_time[i] <= now) begin
        age = now - ring_time[i];
        if (age >= TS_W'(window_len)) ring_live[i] = 1'b0;
        else acc += 64'(ring_hits[i]);
      end
    end
    total = (acc > 64'(32'hFFFF_FFFF)) ? '1 : acc[HITS_W-1:0];
  endtask

  always @(posedge clk) begin
    logic [HITS_W-1:0] want;
    int                i;
    if (!rst_n) begin
      for (i = 0; i < BUCKETS; i++) begin
        ring_live[i] = 1'b0;
        ring_hits[i] = '0;
      end
      window_len = WINDOW_RESET;
      expected_totals.delete();
      open_totals <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          report_mismatch("result with no query waiting", '0, out_hit_total);
        end else begin
          want = expected_totals.pop_front();
          if (out_hit_total !== want) report_mismatch("hit_total", want, out_hit_total);
        end
      end
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_HIT) begin
          add_hit(in_timestamp);
        end else begin
          sweep_window(in_timestamp, want);
          expected_totals.push_back(want);
        end
      end
      // only the window register exists; other indexes drop the write
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_WINDOW)
        window_len = pwdata[WIN_W-1:0];
      open_totals <= expected_totals.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_hit_counter_core_tb.sv =====
// Top of the sliding-window hit counter testbench: clock, reset, stimulus and verdict.
`default_nettype none

module sliding_window_hit_counter_core_tb
  import swhc_pkg::*;
();

  localparam int LIMIT       = 5_000_000;
  localparam int SETTLE      = 64;
  localparam int BATCH_ITEMS = 305;
  localparam int MAX_GAP     = 40;

  localparam logic [CFG_AW-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
  localparam logic [CFG_AW-1:0] BAD_ADDR    = {~REG_WINDOW, 2'b00};

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_cmd       = CMD_HIT;
  logic [TS_W-1:0]   in_timestamp = '0;
  logic              out_ready    = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [CFG_AW-1:0] paddr        = '0;
  logic [CFG_DW-1:0] pwdata       = '0;

  logic              in_ready;
  logic              out_valid;
  logic [HITS_W-1:0] out_hit_total;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int              fail_count;
  int              open_totals;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              cycles;
  logic [TS_W-1:0] tnow;

  sliding_window_hit_counter_core i_dut (.*);

  sliding_window_hit_counter_checker i_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic drive_item(input logic cmd, input logic [31:0] ts);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_timestamp <= ts[TS_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain: wait for every query total, then let trailing hits retire.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_totals != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_batch(input int count, input logic [WIN_W-1:0] win);
    logic [CFG_DW-1:0] data;
    logic              cmd;
    int                r;
    int                n;
    settle();
    // junk in the upper bits must not reach the window
    data = $urandom;
    data[WIN_W-1:0] = win;
    cfg_write(WINDOW_ADDR, data);
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 2) tnow = TS_W'($urandom);
      else if (r < 5) tnow = tnow - TS_W'($urandom_range(600, 1));
      else if (r >= 95) tnow = tnow + TS_W'($urandom_range(1100, 41));
      else if (r >= 50) tnow = tnow + TS_W'($urandom_range(40, 1));
      cmd = ($urandom_range(99) < 30) ? CMD_QUERY : CMD_HIT;
      drive_item(cmd, {1'b0, tnow});
    end
  endtask

  initial begin
    tx_idle_pct = 19;
    rx_idle_pct = 45;
    tnow        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset window: empty query, repeats, window edge, slot collisions, late query
    drive_item(CMD_QUERY, 0);
    drive_item(CMD_HIT, 0);
    drive_item(CMD_HIT, 0);
    drive_item(CMD_HIT, 5);
    drive_item(CMD_QUERY, 5);
    drive_item(CMD_QUERY, 299);
    drive_item(CMD_QUERY, 300);
    drive_item(CMD_HIT, 517);
    drive_item(CMD_QUERY, 517);
    drive_item(CMD_HIT, 10);
    drive_item(CMD_QUERY, 10);
    drive_item(CMD_HIT, '1);
    drive_item(CMD_HIT, '1);
    drive_item(CMD_QUERY, '1);

    // zero window counts nothing and expires everything up to now
    settle();
    cfg_write(WINDOW_ADDR, 0);
    drive_item(CMD_QUERY, '1);
    drive_item(CMD_HIT, 100);
    drive_item(CMD_QUERY, 100);

    // widest window; a write to an unmapped index must leave it alone
    settle();
    cfg_write(WINDOW_ADDR, 1023);
    cfg_write(BAD_ADDR, 5);
    drive_item(CMD_HIT, 1000);
    drive_item(CMD_HIT, 1500);
    drive_item(CMD_QUERY, 2000);

    tnow = TS_W'(2000);
    random_batch(BATCH_ITEMS, WIN_W'(1));
    random_batch(BATCH_ITEMS, WIN_W'(512));

    tx_idle_pct = 45;
    rx_idle_pct = 19;
    random_batch(BATCH_ITEMS, WIN_W'($urandom_range(511, 2)));
    random_batch(BATCH_ITEMS, WIN_W'($urandom_range(1023, 513)));

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_batch(BATCH_ITEMS, WIN_W'(64));
    random_batch(BATCH_ITEMS, WIN_W'($urandom_range(1023, 1)));

    settle();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
